@@ hw/rtl/wheel_speed_smoother_core_assert.svh @@
// Assertion macros for the file that checks the smoother.
`ifndef WHEEL_SPEED_SMOOTHER_CORE_ASSERT_SVH
`define WHEEL_SPEED_SMOOTHER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and off during reset.
`define WSS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and off during reset.
`define WSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/wss_pkg.sv @@
package wss_pkg;

	// Fixed widths of the speed path.
	localparam int VAL_W   = 24;
	localparam int MUL_A_W = 24;
	localparam int MUL_B_W = 17;
	localparam int ACC_W   = 42;
	localparam int REM_W   = 26;
	localparam int DEN_W   = 25;
	localparam int NOISE_W = 16;
	localparam int ALPHA_W = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam int DEF_COUNT_BITS = 12;
	localparam int DEF_FRAC_BITS  = 8;

	// Gain is Q1.16; the divider produces one quotient bit per step.
	localparam int GAIN_SHIFT = 16;
	localparam int DIV_STEPS  = GAIN_SHIFT + 1;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
	localparam logic [MUL_B_W-1:0] GAIN_ONE = MUL_B_W'(65536);
	localparam logic [ACC_W-1:0]   KAL_RND  = ACC_W'(32768);

	// EMA weight is Q1.8.
	localparam int ALPHA_SHIFT = 8;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(256);
	localparam logic [ACC_W-1:0]   EMA_RND   = ACC_W'(128);

	localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

	// Display offsets in whole cm/s, covariance reset in whole units.
	localparam int OFFSET_LO  = 10;
	localparam int OFFSET_MID = 18;
	localparam int OFFSET_HI  = 30;
	localparam int COV_INIT   = 100;

	// Register defaults.
	localparam logic [15:0] PULSE_SCALE_RST = 16'd2694;
	localparam logic [ALPHA_W-1:0] EMA_ALPHA_RST = 9'd230;
	localparam logic [NOISE_W-1:0] PROC_NOISE_RST = 16'd3840;
	localparam logic [NOISE_W-1:0] MEAS_NOISE_RST = 16'd128;
	localparam logic [VAL_W-1:0] LOW_BAND_RST  = 24'd20480;
	localparam logic [VAL_W-1:0] HIGH_BAND_RST = 24'd32000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FILTER_MODE = 3'd0,
		CFG_PULSE_SCALE = 3'd1,
		CFG_EMA_ALPHA   = 3'd2,
		CFG_PROC_NOISE  = 3'd3,
		CFG_MEAS_NOISE  = 3'd4,
		CFG_LOW_BAND    = 3'd5,
		CFG_HIGH_BAND   = 3'd6
	} cfg_idx_t;

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_RAW  = 11'b00000000010,
		S_SEL  = 11'b00000000100,
		S_EMA1 = 11'b00000001000,
		S_EMA2 = 11'b00000010000,
		S_EMA3 = 11'b00000100000,
		S_DIV  = 11'b00001000000,
		S_K1   = 11'b00010000000,
		S_K2   = 11'b00100000000,
		S_K3   = 11'b01000000000,
		S_BAND = 11'b10000000000
	} state_t;

	// Command to the shared multiply-accumulate unit.
	typedef struct packed {
		logic             en;
		logic             clr;
		logic [ACC_W-1:0] bias;
	} mac_cmd_t;

	// Status of the gain divider.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

@@ hw/rtl/wss_mac.sv @@
module wss_mac (
	input  logic                         clk,
	input  logic                         arst_n,
	input  wss_pkg::mac_cmd_t            cmd,
	input  logic [wss_pkg::MUL_A_W-1:0]  a,
	input  logic [wss_pkg::MUL_B_W-1:0]  b,
	output logic [wss_pkg::ACC_W-1:0]    acc
);

	logic [wss_pkg::MUL_A_W+wss_pkg::MUL_B_W-1:0] prod;
	logic [wss_pkg::ACC_W-1:0] base;
	logic [wss_pkg::ACC_W-1:0] acc_q;

	assign prod = a * b;
	assign base = cmd.clr ? cmd.bias : acc_q;

	// The accumulator starts from the rounding bias on a fresh sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.en) begin
			acc_q <= base + wss_pkg::ACC_W'(prod);
		end
	end

	assign acc = acc_q;

endmodule

@@ hw/rtl/wss_div.sv @@
module wss_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [wss_pkg::VAL_W-1:0]     p,
	input  logic [wss_pkg::NOISE_W-1:0]   r,
	output wss_pkg::div_stat_t            stat,
	output logic [wss_pkg::MUL_B_W-1:0]   quot
);

	logic [wss_pkg::DEN_W-1:0]     den_q;
	logic [wss_pkg::REM_W-1:0]     rem_q;
	logic [wss_pkg::MUL_B_W-1:0]   quot_q;
	logic [wss_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic                          ge;
	logic [wss_pkg::REM_W-1:0]     rem_sub;

	// Restoring division of p * 2^16 by p + r; p never exceeds the divisor,
	// so the quotient fits in seventeen bits.
	assign ge      = rem_q >= wss_pkg::REM_W'(den_q);
	assign rem_sub = ge ? (rem_q - wss_pkg::REM_W'(den_q)) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= wss_pkg::DIV_CNT_W'(wss_pkg::DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == wss_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q  <= wss_pkg::DEN_W'(p) + wss_pkg::DEN_W'(r);
			rem_q  <= wss_pkg::REM_W'(p);
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= {rem_sub[wss_pkg::REM_W-2:0], 1'b0};
			quot_q <= {quot_q[wss_pkg::MUL_B_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quot_q;

endmodule

@@ hw/rtl/wheel_speed_smoother_core.sv @@
// Wheel speed smoother. Each item is the encoder pulse count of one sample
// window; it is scaled by pulse_scale to a speed in cm/s (unsigned, FRAC_BITS
// fraction bits, clipped to 24 bits), smoothed by an exponential moving
// average (filter_mode 0) or a scalar Kalman filter (filter_mode 1), and given
// a band offset of 10, 18 or 30 cm/s with clipping. A result item leaves only
// when the displayed speed differs from the last one shown. The block takes
// one item at a time: pulse_stall is high from acceptance until the item is
// finished. An averaging item passes through the blend states when the
// reading is blended, and goes from selection straight to the band state when
// a zero or lower reading is taken over directly. A Kalman item waits on the
// serial gain divider, which produces one quotient bit per clock, and all
// multiplications share one 24 x 17 multiply-accumulate unit. When an item
// changes the displayed value, it stays in the band state for as long as a
// previous result still waits in the output register. Configuration writes
// are always accepted (cfg_ready is tied high) and must only be made while
// the block is idle.
`include "wheel_speed_smoother_core_assert.svh"

module wheel_speed_smoother_core #(
	parameter int COUNT_BITS = wss_pkg::DEF_COUNT_BITS,
	parameter int FRAC_BITS  = wss_pkg::DEF_FRAC_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Input items.
	input  logic                             pulse_valid,
	output logic                             pulse_stall,
	input  logic [COUNT_BITS-1:0]            pulse_count,
	// Result items.
	output logic                             speed_valid,
	input  logic                             speed_stall,
	output logic [wss_pkg::VAL_W-1:0]        display_speed,
	output logic [wss_pkg::VAL_W-1:0]        filtered_speed,
	// Configuration writes.
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [wss_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wss_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int VW = wss_pkg::VAL_W;

	// Offsets and covariance reset scaled to the fraction width.
	localparam logic [VW:0] OFF_LO  = (VW+1)'(wss_pkg::OFFSET_LO  << FRAC_BITS);
	localparam logic [VW:0] OFF_MID = (VW+1)'(wss_pkg::OFFSET_MID << FRAC_BITS);
	localparam logic [VW:0] OFF_HI  = (VW+1)'(wss_pkg::OFFSET_HI  << FRAC_BITS);
	localparam logic [VW-1:0] COV_RST = VW'(wss_pkg::COV_INIT << FRAC_BITS);

	// Clip an accumulator value to the 24-bit speed range.
	function automatic logic [VW-1:0] sat_val(input logic [wss_pkg::ACC_W-1:0] v);
		logic [VW-1:0] res;
		res = (|v[wss_pkg::ACC_W-1:VW]) ? wss_pkg::VAL_MAX : v[VW-1:0];
		return res;
	endfunction

	// Configuration registers.
	logic                          filter_mode_q;
	logic [15:0]                   pulse_scale_q;
	logic [wss_pkg::ALPHA_W-1:0]   ema_alpha_q;
	logic [wss_pkg::NOISE_W-1:0]   proc_noise_q;
	logic [wss_pkg::NOISE_W-1:0]   meas_noise_q;
	logic [VW-1:0]                 low_band_q;
	logic [VW-1:0]                 high_band_q;

	// Filter state and working registers.
	wss_pkg::state_t               state_q;
	logic [COUNT_BITS-1:0]         count_q;
	logic [VW-1:0]                 raw_q;
	logic [VW-1:0]                 smooth_q;
	logic [VW-1:0]                 est_q;
	logic [VW-1:0]                 cov_q;
	logic [VW-1:0]                 p_q;
	logic [wss_pkg::MUL_B_W-1:0]   gain_q;
	logic [VW-1:0]                 filt_q;
	logic [VW-1:0]                 last_q;
	logic                          out_valid_q;
	logic [VW-1:0]                 disp_q;
	logic [VW-1:0]                 fspd_q;

	// Shared units.
	wss_pkg::mac_cmd_t             mac_cmd;
	logic [wss_pkg::MUL_A_W-1:0]   mac_a;
	logic [wss_pkg::MUL_B_W-1:0]   mac_b;
	logic [wss_pkg::ACC_W-1:0]     acc;
	wss_pkg::div_stat_t            div_stat;
	logic [wss_pkg::MUL_B_W-1:0]   quot;
	logic                          div_start;

	logic                          accept;
	logic [wss_pkg::ALPHA_W-1:0]   alpha_c;
	logic [VW-1:0]                 raw_new;
	logic [VW:0]                   p_sum;
	logic [VW-1:0]                 p_new;
	logic [wss_pkg::MUL_B_W-1:0]   gain_c;
	logic [wss_pkg::MUL_B_W-1:0]   gain_inv;
	logic [VW:0]                   offset;
	logic [VW:0]                   shown_sum;
	logic [VW-1:0]                 shown;
	logic                          out_free;
	logic                          emit;

	assign cfg_ready   = 1'b1;
	assign accept      = pulse_valid && !pulse_stall;
	assign pulse_stall = (state_q != wss_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_mode_q <= 1'b0;
			pulse_scale_q <= wss_pkg::PULSE_SCALE_RST;
			ema_alpha_q   <= wss_pkg::EMA_ALPHA_RST;
			proc_noise_q  <= wss_pkg::PROC_NOISE_RST;
			meas_noise_q  <= wss_pkg::MEAS_NOISE_RST;
			low_band_q    <= wss_pkg::LOW_BAND_RST;
			high_band_q   <= wss_pkg::HIGH_BAND_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				wss_pkg::CFG_FILTER_MODE: filter_mode_q <= cfg_data[0];
				wss_pkg::CFG_PULSE_SCALE: pulse_scale_q <= cfg_data[15:0];
				wss_pkg::CFG_EMA_ALPHA:   ema_alpha_q   <= cfg_data[wss_pkg::ALPHA_W-1:0];
				wss_pkg::CFG_PROC_NOISE:  proc_noise_q  <= cfg_data[wss_pkg::NOISE_W-1:0];
				wss_pkg::CFG_MEAS_NOISE:  meas_noise_q  <= cfg_data[wss_pkg::NOISE_W-1:0];
				wss_pkg::CFG_LOW_BAND:    low_band_q    <= cfg_data[VW-1:0];
				wss_pkg::CFG_HIGH_BAND:   high_band_q   <= cfg_data[VW-1:0];
				default: begin
				end
			endcase
		end
	end

	// Weights above one act as one.
	assign alpha_c = (ema_alpha_q > wss_pkg::ALPHA_ONE) ? wss_pkg::ALPHA_ONE : ema_alpha_q;

	// Raw speed is read from the accumulator in the cycle after the scaling product.
	assign raw_new = sat_val(acc);

	// Predicted covariance, clipped.
	assign p_sum = {1'b0, cov_q} + (VW+1)'(proc_noise_q);
	assign p_new = p_sum[VW] ? wss_pkg::VAL_MAX : p_sum[VW-1:0];

	// A zero divisor leaves every quotient bit set, which clamps to a gain of one.
	assign gain_c   = (quot > wss_pkg::GAIN_ONE) ? wss_pkg::GAIN_ONE : quot;
	assign gain_inv = wss_pkg::GAIN_ONE - gain_q;

	assign div_start = (state_q == wss_pkg::S_SEL) && filter_mode_q;

	// Operand selection for the shared multiply-accumulate unit.
	always_comb begin
		mac_cmd = '0;
		mac_a   = '0;
		mac_b   = '0;
		unique case (state_q)
			wss_pkg::S_RAW: begin
				mac_cmd = '{en: 1'b1, clr: 1'b1, bias: '0};
				mac_a   = wss_pkg::MUL_A_W'(count_q);
				mac_b   = wss_pkg::MUL_B_W'(pulse_scale_q);
			end
			wss_pkg::S_EMA1: begin
				mac_cmd = '{en: 1'b1, clr: 1'b1, bias: wss_pkg::EMA_RND};
				mac_a   = raw_q;
				mac_b   = wss_pkg::MUL_B_W'(alpha_c);
			end
			wss_pkg::S_EMA2: begin
				mac_cmd = '{en: 1'b1, clr: 1'b0, bias: '0};
				mac_a   = smooth_q;
				mac_b   = wss_pkg::MUL_B_W'(wss_pkg::ALPHA_ONE - alpha_c);
			end
			wss_pkg::S_K1: begin
				mac_cmd = '{en: 1'b1, clr: 1'b1, bias: wss_pkg::KAL_RND};
				mac_a   = est_q;
				mac_b   = gain_inv;
			end
			wss_pkg::S_K2: begin
				mac_cmd = '{en: 1'b1, clr: 1'b0, bias: '0};
				mac_a   = raw_q;
				mac_b   = gain_q;
			end
			wss_pkg::S_K3: begin
				// The estimate is taken from the accumulator in this cycle while
				// the covariance product starts a fresh sum.
				mac_cmd = '{en: 1'b1, clr: 1'b1, bias: wss_pkg::KAL_RND};
				mac_a   = p_q;
				mac_b   = gain_inv;
			end
			default: begin
			end
		endcase
	end

	// Band offset and clipped display value.
	always_comb begin
		if (filt_q < low_band_q) begin
			offset = OFF_LO;
		end else if (filt_q < high_band_q) begin
			offset = OFF_MID;
		end else begin
			offset = OFF_HI;
		end
	end
	assign shown_sum = {1'b0, filt_q} + offset;
	assign shown     = shown_sum[VW] ? wss_pkg::VAL_MAX : shown_sum[VW-1:0];
	assign out_free  = !out_valid_q || !speed_stall;

	// A changed display value moves into the output register in this cycle.
	assign emit = (state_q == wss_pkg::S_BAND) && (shown != last_q) && out_free;

	// Sequencer with filter state. The covariance update of one Kalman item is
	// folded into the band cycle, where the accumulator holds P * (1 - K).
	logic cov_pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= wss_pkg::S_IDLE;
			smooth_q      <= '0;
			est_q         <= '0;
			cov_q         <= COV_RST;
			last_q        <= '0;
			out_valid_q   <= 1'b0;
			cov_pending_q <= 1'b0;
		end else begin
			if (out_valid_q && !speed_stall && !emit) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				wss_pkg::S_IDLE: begin
					if (accept) begin
						state_q <= wss_pkg::S_RAW;
					end
				end
				wss_pkg::S_RAW: begin
					state_q <= wss_pkg::S_SEL;
				end
				wss_pkg::S_SEL: begin
					if (filter_mode_q) begin
						if (raw_new == '0) begin
							est_q <= '0;
						end
						state_q <= wss_pkg::S_DIV;
					end else if (raw_new == '0) begin
						smooth_q <= '0;
						state_q  <= wss_pkg::S_BAND;
					end else if (raw_new < smooth_q) begin
						smooth_q <= raw_new;
						state_q  <= wss_pkg::S_BAND;
					end else begin
						state_q <= wss_pkg::S_EMA1;
					end
				end
				wss_pkg::S_EMA1: begin
					state_q <= wss_pkg::S_EMA2;
				end
				wss_pkg::S_EMA2: begin
					state_q <= wss_pkg::S_EMA3;
				end
				wss_pkg::S_EMA3: begin
					smooth_q <= sat_val(acc >> wss_pkg::ALPHA_SHIFT);
					state_q  <= wss_pkg::S_BAND;
				end
				wss_pkg::S_DIV: begin
					if (div_stat.done) begin
						state_q <= wss_pkg::S_K1;
					end
				end
				wss_pkg::S_K1: begin
					state_q <= wss_pkg::S_K2;
				end
				wss_pkg::S_K2: begin
					state_q <= wss_pkg::S_K3;
				end
				wss_pkg::S_K3: begin
					est_q         <= sat_val(acc >> wss_pkg::GAIN_SHIFT);
					cov_pending_q <= 1'b1;
					state_q       <= wss_pkg::S_BAND;
				end
				wss_pkg::S_BAND: begin
					if (cov_pending_q) begin
						cov_q         <= sat_val(acc >> wss_pkg::GAIN_SHIFT);
						cov_pending_q <= 1'b0;
					end
					if (shown == last_q) begin
						state_q <= wss_pkg::S_IDLE;
					end else if (out_free) begin
						last_q      <= shown;
						out_valid_q <= 1'b1;
						state_q     <= wss_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= wss_pkg::S_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			count_q <= pulse_count;
		end
		if (state_q == wss_pkg::S_SEL) begin
			raw_q <= raw_new;
			p_q   <= p_new;
		end
		if (div_stat.done) begin
			gain_q <= gain_c;
		end
		// The filtered value follows whichever filter just finished.
		unique case (state_q)
			wss_pkg::S_SEL: begin
				if (!filter_mode_q) begin
					filt_q <= (raw_new < smooth_q) ? raw_new : smooth_q;
				end
			end
			wss_pkg::S_EMA3: filt_q <= sat_val(acc >> wss_pkg::ALPHA_SHIFT);
			wss_pkg::S_K3:   filt_q <= sat_val(acc >> wss_pkg::GAIN_SHIFT);
			default: begin
			end
		endcase
		if (state_q == wss_pkg::S_BAND && shown != last_q && out_free) begin
			disp_q <= shown;
			fspd_q <= filt_q;
		end
	end

	wss_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mac_cmd),
		.a      (mac_a),
		.b      (mac_b),
		.acc    (acc)
	);

	wss_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.p      (p_new),
		.r      (meas_noise_q),
		.stat   (div_stat),
		.quot   (quot)
	);

	assign speed_valid    = out_valid_q;
	assign display_speed  = disp_q;
	assign filtered_speed = fspd_q;

	// The divider only finishes while the sequencer waits for the gain.
	`WSS_ASSERT_NOW(a_div_done_in_wait, div_stat.done, state_q == wss_pkg::S_DIV, "gain divider finished outside its wait state")
	// An accepted item always starts with the scaling product.
	`WSS_ASSERT_NEXT(a_accept_starts, accept, state_q == wss_pkg::S_RAW, "accepted item did not start scaling")
	// A changed display value always leaves as a result item.
	`WSS_ASSERT_NEXT(a_change_shown, state_q == wss_pkg::S_BAND && shown != last_q && out_free, speed_valid && display_speed == last_q, "changed display value was not presented")
	// The covariance update is only pending on its way through the band cycle.
	`WSS_ASSERT_NOW(a_cov_pending, cov_pending_q, state_q == wss_pkg::S_BAND, "covariance update pending outside the band cycle")

endmodule
